### sv/riff_wave_chunk_parser_defines.svh
// assertion macros of the riff wave chunk parser rtl, used by the result stage
`ifndef RIFF_WAVE_CHUNK_PARSER_DEFINES_SVH
`define RIFF_WAVE_CHUNK_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent holds in this cycle, consequent in the same cycle
`define RWCP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define RWCP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RWCP_ASSERT_IMP(label, ante, cons, msg)
`define RWCP_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### sv/rwcp_pkg.sv
// types, codes and constants of the riff wave chunk parser
package rwcp_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_CHUNK_HDR,
      PH_PAYLOAD,
      PH_PAD,
      PH_SKIP
   } rwcp_phase_type;

   // verdict codes of the status item
   typedef enum logic [2:0] {
      ST_VALID       = 3'd0,
      ST_BAD_HEADER  = 3'd1,
      ST_NO_FORMAT   = 3'd2,
      ST_NO_DATA     = 3'd3,
      ST_UNSUPPORTED = 3'd4
   } rwcp_status_type;

   // result kinds
   localparam logic KIND_PCM    = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // little-endian four character codes
   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   // header byte positions
   localparam logic [3:0] ID_LAST_BYTE   = 4'd3;
   localparam logic [3:0] HDR_LAST_BYTE  = 4'd11;
   localparam logic [3:0] CHUNK_HDR_LAST = 4'd7;

   // smallest fmt chunk that carries all fields
   localparam logic [31:0] FMT_MIN = 32'd16;
   localparam logic [15:0] PCM_TAG = 16'd1;

   // record queue between parser and result stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [15:0] format_tag;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
   } rwcp_fmt_type;

   // what one input byte leaves for the result stage
   typedef struct packed {
      logic            has_pcm;
      logic [7:0]      pcm_byte;
      logic            new_chunk;
      logic            has_status;
      rwcp_fmt_type    fmt;
      rwcp_status_type status;
      logic            truncated;
   } rwcp_rec_type;

   // split the first sixteen fmt payload bytes into fields
   function automatic rwcp_fmt_type unpack_fmt(input logic [127:0] raw);
      rwcp_fmt_type f;
      f.format_tag      = raw[15:0];
      f.channel_count   = raw[31:16];
      f.sample_rate     = raw[63:32];
      f.byte_rate       = raw[95:64];
      f.block_align     = raw[111:96];
      f.bits_per_sample = raw[127:112];
      return f;
   endfunction

endpackage

### sv/riff_wave_chunk_parser.sv
// riff wave chunk parser top level: parser, record queue and result stage
//
//   channel   direction  handshake          payload
//   req       in         push / full        file_byte, end_of_file
//   rsp       out        pop / empty        kind, pcm_byte, new_data_chunk, fmt fields,
//                                           status, data_truncated, last
//
// one byte is accepted per cycle while full is low; the parser updates its counters in that cycle
// a record waits in a four entry queue until the output register is empty or being popped
// a byte with the end of file mark inside a data payload gives two items, a pcm item then a status item
// full rises only when the record queue is full, set by how fast the consumer pops
// synchronous reset returns the parser to the riff magic and empties queue and output
module riff_wave_chunk_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_file_byte,
   input  logic        req_end_of_file,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic        rsp_kind,
   output logic [7:0]  rsp_pcm_byte,
   output logic        rsp_new_data_chunk,
   output logic [15:0] rsp_format_tag,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [31:0] rsp_byte_rate,
   output logic [15:0] rsp_block_align,
   output logic [15:0] rsp_bits_per_sample,
   output logic [2:0]  rsp_status,
   output logic        rsp_data_truncated,
   output logic        rsp_last
);
   import rwcp_pkg::*;

   logic         accept;
   logic         rec_valid;
   rwcp_rec_type rec;
   logic         head_valid;
   rwcp_rec_type head_rec;
   logic         head_pop;

   assign accept = req_push && !req_full;

   // front: byte parser
   rwcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .file_byte   (req_file_byte),
      .end_of_file (req_end_of_file),
      .rec_valid   (rec_valid),
      .rec         (rec)
   );

   // record queue
   rwcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rec_valid),
      .push_rec   (rec),
      .full       (req_full),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (head_pop)
   );

   // back: result items
   rwcp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_rec            (head_rec),
      .head_pop            (head_pop),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_kind            (rsp_kind),
      .rsp_pcm_byte        (rsp_pcm_byte),
      .rsp_new_data_chunk  (rsp_new_data_chunk),
      .rsp_format_tag      (rsp_format_tag),
      .rsp_channel_count   (rsp_channel_count),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_byte_rate       (rsp_byte_rate),
      .rsp_block_align     (rsp_block_align),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_status          (rsp_status),
      .rsp_data_truncated  (rsp_data_truncated),
      .rsp_last            (rsp_last)
   );

endmodule

### sv/rwcp_front.sv
// byte parser: header and chunk walk, fmt capture, record build
module rwcp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            file_byte,
   input  logic                  end_of_file,
   output logic                  rec_valid,
   output rwcp_pkg::rwcp_rec_type rec
);
   import rwcp_pkg::*;

   rwcp_phase_type phase_ff, phase_in;
   logic [3:0]     offset_ff, offset_in;
   logic [31:0]    word_ff, word_in, word_next;
   logic           id_fmt_ff, id_fmt_in;
   logic           id_data_ff, id_data_in;
   logic [31:0]    remaining_ff, remaining_in;
   logic [4:0]     idx_ff, idx_in;
   logic           fmt_ok_ff, fmt_ok_in;
   logic           pad_ff, pad_in;
   logic           header_ok_ff, header_ok_in;
   logic [127:0]   scratch_ff, scratch_in;
   logic [127:0]   committed_ff, committed_in;
   logic           has_format_ff, has_format_in;
   logic           has_data_ff, has_data_in;
   logic           data_open_ff, data_open_in;

   // values after this byte, before the end of file clear
   logic [127:0]   committed_upd;
   logic           header_ok_upd;
   logic           has_format_upd;
   logic           has_data_upd;
   logic           data_open_upd;
   logic           last_payload;
   rwcp_fmt_type   fmt_view;
   rwcp_status_type verdict;

   assign word_next    = {file_byte, word_ff[31:8]};
   assign last_payload = (remaining_ff == 32'd1);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (offset_ff == ID_LAST_BYTE && word_next != ID_RIFF) begin
               phase_in = PH_SKIP;
            end else if (offset_ff == HDR_LAST_BYTE) begin
               phase_in = (word_next == ID_WAVE) ? PH_CHUNK_HDR : PH_SKIP;
            end
         end
         PH_CHUNK_HDR: begin
            if (offset_ff == CHUNK_HDR_LAST && word_next != 32'd0) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (last_payload) begin
               phase_in = pad_ff ? PH_PAD : PH_CHUNK_HDR;
            end
         end
         PH_PAD: begin
            phase_in = PH_CHUNK_HDR;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      if (end_of_file) begin
         phase_in = PH_HEADER;
      end
   end

   // counters, chunk fields and fmt capture
   always_comb begin
      offset_in      = offset_ff;
      word_in        = word_next;
      id_fmt_in      = id_fmt_ff;
      id_data_in     = id_data_ff;
      remaining_in   = remaining_ff;
      idx_in         = idx_ff;
      fmt_ok_in      = fmt_ok_ff;
      pad_in         = pad_ff;
      header_ok_upd  = header_ok_ff;
      scratch_in     = scratch_ff;
      committed_upd  = committed_ff;
      has_format_upd = has_format_ff;
      has_data_upd   = has_data_ff;
      data_open_upd  = data_open_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (offset_ff == ID_LAST_BYTE && word_next != ID_RIFF) begin
               offset_in = offset_ff;
            end else if (offset_ff == HDR_LAST_BYTE) begin
               header_ok_upd = (word_next == ID_WAVE);
               offset_in     = 4'd0;
            end else begin
               offset_in = offset_ff + 4'd1;
            end
         end
         PH_CHUNK_HDR: begin
            if (offset_ff == ID_LAST_BYTE) begin
               id_fmt_in  = (word_next == ID_FMT);
               id_data_in = (word_next == ID_DATA);
            end
            if (offset_ff == CHUNK_HDR_LAST) begin
               remaining_in = word_next;
               pad_in       = word_next[0];
               fmt_ok_in    = id_fmt_ff && (word_next >= FMT_MIN);
               idx_in       = 5'd0;
               offset_in    = 4'd0;
            end else begin
               offset_in = offset_ff + 4'd1;
            end
         end
         PH_PAYLOAD: begin
            // first sixteen bytes of a large enough fmt chunk
            if (fmt_ok_ff && !idx_ff[4]) begin
               scratch_in[{idx_ff[3:0], 3'b000} +: 8] = file_byte;
            end
            if (id_data_ff && idx_ff == 5'd0) begin
               data_open_upd = 1'b1;
               has_data_upd  = 1'b1;
            end
            idx_in       = idx_ff[4] ? idx_ff : idx_ff + 5'd1;
            remaining_in = remaining_ff - 32'd1;
            if (last_payload) begin
               if (fmt_ok_ff) begin
                  committed_upd  = scratch_in;
                  has_format_upd = 1'b1;
               end
               data_open_upd = 1'b0;
               offset_in     = 4'd0;
            end
         end
         PH_PAD: begin
            pad_in = 1'b0;
         end
         default: begin
            offset_in = offset_ff;
         end
      endcase
   end

   // verdict from the state after this byte
   assign fmt_view = unpack_fmt(committed_upd);

   always_comb begin
      if (!header_ok_upd) begin
         verdict = ST_BAD_HEADER;
      end else if (!has_format_upd) begin
         verdict = ST_NO_FORMAT;
      end else if (!has_data_upd) begin
         verdict = ST_NO_DATA;
      end else if (fmt_view.format_tag != PCM_TAG || fmt_view.channel_count == 16'd0 ||
                   fmt_view.sample_rate == 32'd0 || fmt_view.block_align == 16'd0) begin
         verdict = ST_UNSUPPORTED;
      end else begin
         verdict = ST_VALID;
      end
   end

   // end of file returns the file state to reset
   assign header_ok_in  = end_of_file ? 1'b0 : header_ok_upd;
   assign committed_in  = end_of_file ? 128'd0 : committed_upd;
   assign has_format_in = end_of_file ? 1'b0 : has_format_upd;
   assign has_data_in   = end_of_file ? 1'b0 : has_data_upd;
   assign data_open_in  = end_of_file ? 1'b0 : data_open_upd;

   // record for the result stage
   always_comb begin
      rec.has_pcm    = (phase_ff == PH_PAYLOAD) && id_data_ff;
      rec.pcm_byte   = file_byte;
      rec.new_chunk  = (idx_ff == 5'd0);
      rec.has_status = end_of_file;
      rec.fmt        = fmt_view;
      rec.status     = verdict;
      rec.truncated  = data_open_upd;
   end

   assign rec_valid = accept && (rec.has_pcm || rec.has_status);

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         offset_ff     <= 4'd0;
         word_ff       <= 32'd0;
         id_fmt_ff     <= 1'b0;
         id_data_ff    <= 1'b0;
         remaining_ff  <= 32'd0;
         idx_ff        <= 5'd0;
         fmt_ok_ff     <= 1'b0;
         pad_ff        <= 1'b0;
         header_ok_ff  <= 1'b0;
         committed_ff  <= 128'd0;
         has_format_ff <= 1'b0;
         has_data_ff   <= 1'b0;
         data_open_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         offset_ff     <= end_of_file ? 4'd0 : offset_in;
         word_ff       <= end_of_file ? 32'd0 : word_in;
         id_fmt_ff     <= end_of_file ? 1'b0 : id_fmt_in;
         id_data_ff    <= end_of_file ? 1'b0 : id_data_in;
         remaining_ff  <= end_of_file ? 32'd0 : remaining_in;
         idx_ff        <= end_of_file ? 5'd0 : idx_in;
         fmt_ok_ff     <= end_of_file ? 1'b0 : fmt_ok_in;
         pad_ff        <= end_of_file ? 1'b0 : pad_in;
         header_ok_ff  <= header_ok_in;
         committed_ff  <= committed_in;
         has_format_ff <= has_format_in;
         has_data_ff   <= has_data_in;
         data_open_ff  <= data_open_in;
      end
   end

   // fmt scratch bytes, always fully rewritten before a commit
   always_ff @(posedge clock) begin
      if (accept) begin
         scratch_ff <= scratch_in;
      end
   end

endmodule

### sv/rwcp_queue.sv
// small record queue between the parser and the result stage
module rwcp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rwcp_pkg::rwcp_rec_type push_rec,
   output logic                  full,
   output logic                  head_valid,
   output rwcp_pkg::rwcp_rec_type head_rec,
   input  logic                  pop
);
   import rwcp_pkg::*;

   rwcp_rec_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (count_ff == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // record storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

### sv/rwcp_back.sv
// result stage: splits records into result items, holds the output register
`include "riff_wave_chunk_parser_defines.svh"

module rwcp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  rwcp_pkg::rwcp_rec_type head_rec,
   output logic                  head_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_pcm_byte,
   output logic                  rsp_new_data_chunk,
   output logic [15:0]           rsp_format_tag,
   output logic [15:0]           rsp_channel_count,
   output logic [31:0]           rsp_sample_rate,
   output logic [31:0]           rsp_byte_rate,
   output logic [15:0]           rsp_block_align,
   output logic [15:0]           rsp_bits_per_sample,
   output logic [2:0]            rsp_status,
   output logic                  rsp_data_truncated,
   output logic                  rsp_last
);
   import rwcp_pkg::*;

   logic            out_valid_ff, out_valid_in;
   logic            half_ff, half_in;
   logic            kind_ff, kind_in;
   logic [7:0]      pcm_ff, pcm_in;
   logic            new_chunk_ff, new_chunk_in;
   rwcp_fmt_type    fmt_ff, fmt_in;
   rwcp_status_type status_ff, status_in;
   logic            trunc_ff, trunc_in;
   logic            last_ff, last_in;
   logic            take;
   logic            load;
   logic            emit_pcm;

   // output register handshake
   assign take     = out_valid_ff && rsp_pop;
   assign load     = head_valid && (!out_valid_ff || take);
   assign emit_pcm = head_rec.has_pcm && !half_ff;
   assign head_pop = load && !(emit_pcm && head_rec.has_status);

   // control next values
   always_comb begin
      out_valid_in = out_valid_ff;
      half_in      = half_ff;
      if (load) begin
         out_valid_in = 1'b1;
         half_in      = emit_pcm && head_rec.has_status;
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   // result item built from the queue head
   always_comb begin
      kind_in      = emit_pcm ? KIND_PCM : KIND_STATUS;
      pcm_in       = emit_pcm ? head_rec.pcm_byte : 8'd0;
      new_chunk_in = emit_pcm ? head_rec.new_chunk : 1'b0;
      fmt_in       = emit_pcm ? '0 : head_rec.fmt;
      status_in    = emit_pcm ? ST_VALID : head_rec.status;
      trunc_in     = emit_pcm ? 1'b0 : head_rec.truncated;
      last_in      = emit_pcm ? !head_rec.has_status : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff      <= kind_in;
         pcm_ff       <= pcm_in;
         new_chunk_ff <= new_chunk_in;
         fmt_ff       <= fmt_in;
         status_ff    <= status_in;
         trunc_ff     <= trunc_in;
         last_ff      <= last_in;
      end
   end

   // result ports
   assign rsp_empty           = !out_valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_pcm_byte        = pcm_ff;
   assign rsp_new_data_chunk  = new_chunk_ff;
   assign rsp_format_tag      = fmt_ff.format_tag;
   assign rsp_channel_count   = fmt_ff.channel_count;
   assign rsp_sample_rate     = fmt_ff.sample_rate;
   assign rsp_byte_rate       = fmt_ff.byte_rate;
   assign rsp_block_align     = fmt_ff.block_align;
   assign rsp_bits_per_sample = fmt_ff.bits_per_sample;
   assign rsp_status          = status_ff;
   assign rsp_data_truncated  = trunc_ff;
   assign rsp_last            = last_ff;

   // checks
   `RWCP_ASSERT_IMP(a_rec_not_empty, head_valid, head_rec.has_pcm || head_rec.has_status, "queue record carries no result")
   `RWCP_ASSERT_IMP(a_half_has_status, half_ff, head_valid && head_rec.has_pcm && head_rec.has_status, "status half pending without its record")
   `RWCP_ASSERT_IMP(a_half_out_valid, half_ff, out_valid_ff, "status half pending with empty output register")
   `RWCP_ASSERT_IMP(a_pcm_not_last, out_valid_ff && kind_ff == KIND_PCM && !last_ff, half_ff, "pcm item not last but no status item follows")
   `RWCP_ASSERT_IMP(a_status_last, out_valid_ff && kind_ff == KIND_STATUS, last_ff, "status item not marked last")

endmodule

### sim/riff_wave_chunk_parser_test.sv
// self-checking testbench of the riff wave chunk parser
module riff_wave_chunk_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rwcp_pkg::*;

   localparam int RANDOM_BYTES = 1700;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int PRINT_LIMIT  = 30;

   // one result item as seen on the rsp ports
   typedef struct packed {
      logic            kind;
      logic [7:0]      pcm_byte;
      logic            new_chunk;
      rwcp_fmt_type    fmt;
      rwcp_status_type status;
      logic            truncated;
      logic            last;
   } parser_result_type;

   // predicts the parser byte by byte and checks the items it returns
   class wave_scoreboard;
      parser_result_type owed_results[$];
      int             errors;
      int             results_seen;

      rwcp_phase_type walk_phase;
      int unsigned    hdr_pos;
      logic [31:0]    shift_word;
      logic [31:0]    cur_id;
      logic [31:0]    cur_size;
      logic [32:0]    left;
      bit             pad_due;
      bit             hdr_ok;
      bit             fmt_seen;
      bit             data_seen;
      bit             data_live;
      logic [127:0]   fmt_scratch;
      logic [127:0]   fmt_kept;

      function new();
         errors = 0;
         results_seen = 0;
         restart();
      endfunction

      // parser state after reset and after each end of file
      function void restart();
         walk_phase  = PH_HEADER;
         hdr_pos     = 0;
         shift_word  = '0;
         cur_id      = '0;
         cur_size    = '0;
         left        = '0;
         pad_due     = 1'b0;
         hdr_ok      = 1'b0;
         fmt_seen    = 1'b0;
         data_seen   = 1'b0;
         data_live   = 1'b0;
         fmt_scratch = '0;
         fmt_kept    = '0;
      endfunction

      // one accepted file byte: walk the header and chunks, queue the owed items
      function void take_byte(logic [7:0] b, bit eof);
         parser_result_type made[$];
         parser_result_type r;
         logic [31:0]    idx;
         bit             fmt_chunk;
         case (walk_phase)
            PH_HEADER: begin
               shift_word = {b, shift_word[31:8]};
               if (hdr_pos == ID_LAST_BYTE && shift_word != ID_RIFF) begin
                  walk_phase = PH_SKIP;
               end else if (hdr_pos == HDR_LAST_BYTE) begin
                  if (shift_word == ID_WAVE) begin
                     hdr_ok = 1'b1;
                     walk_phase = PH_CHUNK_HDR;
                  end else begin
                     walk_phase = PH_SKIP;
                  end
                  hdr_pos = 0;
               end else begin
                  hdr_pos++;
               end
            end
            PH_CHUNK_HDR: begin
               shift_word = {b, shift_word[31:8]};
               if (hdr_pos == ID_LAST_BYTE) cur_id = shift_word;
               if (hdr_pos >= CHUNK_HDR_LAST) begin
                  cur_size = shift_word;
                  left = {1'b0, cur_size};
                  pad_due = cur_size[0];
                  hdr_pos = 0;
                  walk_phase = (cur_size != 0) ? PH_PAYLOAD : PH_CHUNK_HDR;
               end else begin
                  hdr_pos++;
               end
            end
            PH_PAYLOAD: begin
               idx = cur_size - left[31:0];
               fmt_chunk = (cur_id == ID_FMT) && (cur_size >= FMT_MIN);
               if (fmt_chunk && idx < FMT_MIN) fmt_scratch[{idx[3:0], 3'b000} +: 8] = b;
               // data payload bytes go out at once
               if (cur_id == ID_DATA) begin
                  r = '0;
                  r.kind = KIND_PCM;
                  r.pcm_byte = b;
                  r.new_chunk = (idx == 0);
                  if (idx == 0) begin
                     data_live = 1'b1;
                     data_seen = 1'b1;
                  end
                  made.push_back(r);
               end
               if (left > 0) left--;
               // chunk complete: commit a full fmt, then pad or next header
               if (left == 0) begin
                  if (fmt_chunk) begin
                     fmt_kept = fmt_scratch;
                     fmt_seen = 1'b1;
                  end
                  data_live = 1'b0;
                  hdr_pos = 0;
                  walk_phase = pad_due ? PH_PAD : PH_CHUNK_HDR;
               end
            end
            PH_PAD: begin
               pad_due = 1'b0;
               walk_phase = PH_CHUNK_HDR;
            end
            default: ;
         endcase

         // end of file: status item with the verdict, then back to reset
         if (eof) begin
            r = '0;
            r.kind = KIND_STATUS;
            r.fmt.format_tag      = fmt_kept[15:0];
            r.fmt.channel_count   = fmt_kept[31:16];
            r.fmt.sample_rate     = fmt_kept[63:32];
            r.fmt.byte_rate       = fmt_kept[95:64];
            r.fmt.block_align     = fmt_kept[111:96];
            r.fmt.bits_per_sample = fmt_kept[127:112];
            if (!hdr_ok) r.status = ST_BAD_HEADER;
            else if (!fmt_seen) r.status = ST_NO_FORMAT;
            else if (!data_seen) r.status = ST_NO_DATA;
            else if (r.fmt.format_tag != PCM_TAG || r.fmt.channel_count == 0 ||
                     r.fmt.sample_rate == 0 || r.fmt.block_align == 0)
               r.status = ST_UNSUPPORTED;
            else r.status = ST_VALID;
            r.truncated = data_live;
            made.push_back(r);
            restart();
         end

         if (made.size() > 0) begin
            made[made.size() - 1].last = 1'b1;
            foreach (made[k]) owed_results.push_back(made[k]);
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
      endtask

      task compare(string field, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("item %0d %s got %0h want %0h", results_seen, field, got, want));
      endtask

      // one accepted result item against the oldest owed one
      task check_result(parser_result_type got);
         parser_result_type want;
         results_seen++;
         if (owed_results.size() == 0) begin
            report($sformatf("item %0d arrived with nothing owed", results_seen));
            return;
         end
         want = owed_results.pop_front();
         compare("kind", got.kind, want.kind);
         compare("pcm_byte", got.pcm_byte, want.pcm_byte);
         compare("new_data_chunk", got.new_chunk, want.new_chunk);
         compare("format_tag", got.fmt.format_tag, want.fmt.format_tag);
         compare("channel_count", got.fmt.channel_count, want.fmt.channel_count);
         compare("sample_rate", got.fmt.sample_rate, want.fmt.sample_rate);
         compare("byte_rate", got.fmt.byte_rate, want.fmt.byte_rate);
         compare("block_align", got.fmt.block_align, want.fmt.block_align);
         compare("bits_per_sample", got.fmt.bits_per_sample, want.fmt.bits_per_sample);
         compare("status", got.status, want.status);
         compare("data_truncated", got.truncated, want.truncated);
         compare("last", got.last, want.last);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [7:0]  req_file_byte = 8'h00;
   logic        req_end_of_file = 1'b0;
   logic        req_full;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic        rsp_kind;
   logic [7:0]  rsp_pcm_byte;
   logic        rsp_new_data_chunk;
   logic [15:0] rsp_format_tag;
   logic [15:0] rsp_channel_count;
   logic [31:0] rsp_sample_rate;
   logic [31:0] rsp_byte_rate;
   logic [15:0] rsp_block_align;
   logic [15:0] rsp_bits_per_sample;
   logic [2:0]  rsp_status;
   logic        rsp_data_truncated;
   logic        rsp_last;

   wave_scoreboard sb;
   logic [7:0]     file_img[$];
   int             bytes_sent = 0;
   int             bytes_in = 0;

   riff_wave_chunk_parser uut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_file_byte       (req_file_byte),
      .req_end_of_file     (req_end_of_file),
      .req_full            (req_full),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_kind            (rsp_kind),
      .rsp_pcm_byte        (rsp_pcm_byte),
      .rsp_new_data_chunk  (rsp_new_data_chunk),
      .rsp_format_tag      (rsp_format_tag),
      .rsp_channel_count   (rsp_channel_count),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_byte_rate       (rsp_byte_rate),
      .rsp_block_align     (rsp_block_align),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_status          (rsp_status),
      .rsp_data_truncated  (rsp_data_truncated),
      .rsp_last            (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void put_word(logic [31:0] w);
      for (int k = 0; k < 4; k++) file_img.push_back(w[8*k +: 8]);
   endfunction

   function automatic void put_half(logic [15:0] h);
      file_img.push_back(h[7:0]);
      file_img.push_back(h[15:8]);
   endfunction

   task idle(int n);
      if (n > 0) begin
         req_push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // offer one item and hold it until the parser takes it
   task send_byte(logic [7:0] b, bit eof);
      req_push <= 1'b1;
      req_file_byte <= b;
      req_end_of_file <= eof;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task send_file(bit steady);
      for (int i = 0; i < file_img.size(); i++) begin
         send_byte(file_img[i], i == file_img.size() - 1);
         if (!steady) idle(pick_gap());
      end
   endtask

   // a random file: mostly well-formed chunk walks, some noise and broken headers
   task make_file();
      int          shape;
      int          n_chunks;
      int          sel;
      int          size;
      int          cut;
      bit          huge;
      logic [31:0] cid;
      file_img.delete();
      shape = $urandom_range(0, 99);
      if (shape < 8) begin
         repeat ($urandom_range(1, 16)) file_img.push_back(8'($urandom));
         return;
      end
      put_word(shape < 11 ? ID_RIFF ^ (32'd1 << $urandom_range(0, 31)) : ID_RIFF);
      put_word($urandom);
      put_word((shape >= 11 && shape < 14) ? ID_WAVE ^ (32'd1 << $urandom_range(0, 31))
                                          : ID_WAVE);
      n_chunks = $urandom_range(0, 5);
      for (int c = 0; c < n_chunks; c++) begin
         sel = $urandom_range(0, 99);
         huge = ($urandom_range(0, 19) == 0);
         if (sel < 35) begin
            cid = ID_FMT;
            sel = $urandom_range(0, 9);
            size = (sel < 7) ? 16 : (sel < 8) ? $urandom_range(17, 21) : $urandom_range(0, 15);
         end else if (sel < 70) begin
            cid = ID_DATA;
            size = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 10) : $urandom_range(11, 40);
         end else begin
            cid = $urandom;
            size = $urandom_range(0, 8);
         end
         put_word(cid);
         // oversized chunk: the file runs out inside its payload
         if (huge) begin
            put_word(32'($urandom) | 32'h8000_0000);
            repeat ($urandom_range(0, 20)) file_img.push_back(8'($urandom));
            break;
         end
         put_word(size);
         if (cid == ID_FMT && size >= 16) begin
            put_half(($urandom_range(0, 9) == 0) ? 16'($urandom) : PCM_TAG);
            put_half(($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8)));
            put_word(($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom));
            put_word($urandom);
            put_half(($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 16)));
            put_half(16'($urandom));
            size -= 16;
         end
         repeat (size) file_img.push_back(8'($urandom));
         if (size % 2 == 1) file_img.push_back(8'($urandom));
      end
      // cut the file short somewhere
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, file_img.size());
         while (file_img.size() > cut) void'(file_img.pop_back());
      end
   endtask

   // sample both handshakes at the edge
   always @(posedge clock) begin
      parser_result_type got;
      if (!reset) begin
         if (req_push && !req_full) begin
            sb.take_byte(req_file_byte, req_end_of_file);
            bytes_in++;
         end
         if (rsp_pop && !rsp_empty) begin
            got.kind = rsp_kind;
            got.pcm_byte = rsp_pcm_byte;
            got.new_chunk = rsp_new_data_chunk;
            got.fmt.format_tag = rsp_format_tag;
            got.fmt.channel_count = rsp_channel_count;
            got.fmt.sample_rate = rsp_sample_rate;
            got.fmt.byte_rate = rsp_byte_rate;
            got.fmt.block_align = rsp_block_align;
            got.fmt.bits_per_sample = rsp_bits_per_sample;
            got.status = rwcp_status_type'(rsp_status);
            got.truncated = rsp_data_truncated;
            got.last = rsp_last;
            sb.check_result(got);
         end
      end
   end

   // consumer: bursts of pops with random gaps, one long hold-off to fill the parser
   initial begin
      int burst;
      int gap;
      bit held;
      held = 1'b0;
      wait (!reset);
      forever begin
         if (!held && bytes_in >= 300) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         burst = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 6);
         repeat (burst) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // stimulus and final verdict
   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // file ends inside the magic word
      file_img.delete();
      file_img.push_back(8'hFF);
      send_file(1'b1);
      // bad riff magic, then end of file
      file_img.delete();
      put_word(ID_RIFF ^ 32'h0100_0000);
      file_img.push_back(8'h00);
      send_file(1'b1);
      // header alone, no chunks
      file_img.delete();
      put_word(ID_RIFF);
      put_word(32'hFFFF_FFFF);
      put_word(ID_WAVE);
      send_file(1'b1);

      while (bytes_sent < RANDOM_BYTES) begin
         make_file();
         send_file($urandom_range(0, 3) == 0);
         idle(pick_gap());
      end
      req_push <= 1'b0;

      // every sent item is noted before the owed items are counted
      wait (bytes_in == bytes_sent);
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.owed_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/rwcp_pkg.sv
sv/rwcp_front.sv
sv/rwcp_queue.sv
sv/rwcp_back.sv
sv/riff_wave_chunk_parser.sv
sim/riff_wave_chunk_parser_test.sv
